// ----- hw/rtl/uct_pkg.sv -----
// shared types, constants and the case-swap function for the uart case-toggle echo
// depends on nothing; uct_fsm, the top level and the testbench import it
package uct_pkg;

  localparam int unsigned DataBits = 8;
  localparam int unsigned BitIdxW  = $clog2(DataBits);
  localparam int unsigned TickW    = 16;

  localparam logic [TickW-1:0]   BitTicksReset = TickW'(104);
  localparam logic [BitIdxW-1:0] LastBit       = BitIdxW'(DataBits - 1);

  localparam logic [7:0] UpperFirst = 8'h41;
  localparam logic [7:0] UpperLast  = 8'h5A;
  localparam logic [7:0] LowerFirst = 8'h61;
  localparam logic [7:0] LowerLast  = 8'h7A;
  localparam logic [7:0] CaseOffset = 8'd32;

  typedef logic [TickW-1:0]    tick_t;
  typedef logic [DataBits-1:0] word_t;
  typedef logic [BitIdxW-1:0]  bit_idx_t;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhStart   = 3'd1,
    PhData    = 3'd2,
    PhStop    = 3'd3,
    PhTxStart = 3'd4,
    PhTxData  = 3'd5,
    PhTxStop  = 3'd6
  } phase_e;

  typedef struct packed {
    logic       tx_level;
    logic       byte_done;
    logic [7:0] rx_byte;
    logic       framing_error;
    logic       false_start;
    logic       busy_res;
  } res_t;

  typedef struct packed {
    logic  step;
    tick_t bit_ticks;
  } step_ctl_t;

  // upper and lower case ascii letters swap, everything else passes
  function automatic word_t swap_case(word_t c);
    logic [7:0] w;
    logic [7:0] r;
    w = 8'(c);
    r = w;
    if (w >= UpperFirst && w <= UpperLast) begin
      r = w + CaseOffset;
    end else if (w >= LowerFirst && w <= LowerLast) begin
      r = w - CaseOffset;
    end
    return DataBits'(r);
  endfunction

endpackage

// ----- hw/rtl/uct_smp_if.sv -----
// line-sample channel: valid/ready plus one receive line sample
// depends on nothing
interface uct_smp_if;
  logic valid;
  logic ready;
  logic rx_level;

  modport source (output valid, output rx_level, input ready);
  modport sink (input valid, input rx_level, output ready);
endinterface

// ----- hw/rtl/uct_res_if.sv -----
// result channel: valid/ready plus the per-sample result fields
// depends on nothing
interface uct_res_if;
  logic       valid;
  logic       ready;
  logic       tx_level;
  logic       byte_done;
  logic [7:0] rx_byte;
  logic       framing_error;
  logic       false_start;
  logic       busy_res;

  modport source (output valid, output tx_level, output byte_done, output rx_byte,
                  output framing_error, output false_start, output busy_res,
                  input ready);
  modport sink (input valid, input tx_level, input byte_done, input rx_byte,
                input framing_error, input false_start, input busy_res,
                output ready);
endinterface

// ----- hw/rtl/uct_cfg_if.sv -----
// configuration write channel: valid/ready plus the bit period in ticks
// depends on nothing
interface uct_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] bit_ticks;

  modport source (output valid, output bit_ticks, input ready);
  modport sink (input valid, input bit_ticks, output ready);
endinterface

// ----- hw/rtl/uct_fsm.sv -----
// frame state machine: receive, case swap and transmit, one line sample per step
// depends on uct_pkg
module uct_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  uct_pkg::step_ctl_t ctl_i,
  input  logic               rx_i,
  output uct_pkg::res_t      res_o
);
  import uct_pkg::*;

  phase_e   phase_q, phase_d;
  tick_t    tick_q, tick_d;
  bit_idx_t bidx_q, bidx_d;
  word_t    rx_shift_q, rx_shift_d;
  word_t    tx_shift_q, tx_shift_d;
  logic     prev_rx_q;

  tick_t target;
  tick_t tick_inc;
  logic  wait_hit;

  assign target   = (phase_q == PhStart) ? (ctl_i.bit_ticks >> 1) : ctl_i.bit_ticks;
  assign tick_inc = tick_q + tick_t'(1);
  assign wait_hit = (tick_inc >= target);

  // next state
  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bidx_d     = bidx_q;
    rx_shift_d = rx_shift_q;
    tx_shift_d = tx_shift_q;
    if (phase_q != PhIdle) begin
      tick_d = wait_hit ? '0 : tick_inc;
    end
    case (phase_q)
      PhIdle: begin
        if (prev_rx_q && !rx_i) begin
          phase_d = PhStart;
          tick_d  = '0;
        end
      end
      PhStart: begin
        if (wait_hit) begin
          phase_d = rx_i ? PhIdle : PhData;
          if (!rx_i) begin
            bidx_d = '0;
          end
        end
      end
      PhData: begin
        if (wait_hit) begin
          rx_shift_d = {rx_i, rx_shift_q[DataBits-1:1]};
          if (bidx_q >= LastBit) begin
            bidx_d  = '0;
            phase_d = PhStop;
          end else begin
            bidx_d = bidx_q + bit_idx_t'(1);
          end
        end
      end
      PhStop: begin
        if (wait_hit) begin
          if (rx_i) begin
            tx_shift_d = swap_case(rx_shift_q);
            bidx_d     = '0;
            phase_d    = PhTxStart;
          end else begin
            phase_d = PhIdle;
          end
        end
      end
      PhTxStart: begin
        if (wait_hit) begin
          bidx_d  = '0;
          phase_d = PhTxData;
        end
      end
      PhTxData: begin
        if (wait_hit) begin
          if (bidx_q >= LastBit) begin
            bidx_d  = '0;
            phase_d = PhTxStop;
          end else begin
            bidx_d = bidx_q + bit_idx_t'(1);
          end
        end
      end
      PhTxStop: begin
        if (wait_hit) begin
          phase_d = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
        tick_d  = '0;
      end
    endcase
  end

  // result of this sample
  always_comb begin
    res_o = '0;
    res_o.tx_level = 1'b1;
    case (phase_q)
      PhStart: begin
        res_o.false_start = wait_hit && rx_i;
      end
      PhStop: begin
        if (wait_hit && rx_i) begin
          res_o.byte_done = 1'b1;
          res_o.rx_byte   = 8'(rx_shift_q);
        end
        res_o.framing_error = wait_hit && !rx_i;
      end
      PhTxStart: begin
        res_o.tx_level = 1'b0;
      end
      PhTxData: begin
        res_o.tx_level = tx_shift_q[bidx_q];
      end
      default: begin
        res_o.tx_level = 1'b1;
      end
    endcase
    res_o.busy_res = (phase_q != PhIdle) || (phase_d != PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      tick_q     <= '0;
      bidx_q     <= '0;
      rx_shift_q <= '0;
      tx_shift_q <= '0;
      prev_rx_q  <= 1'b1;
    end else if (ctl_i.step) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bidx_q     <= bidx_d;
      rx_shift_q <= rx_shift_d;
      tx_shift_q <= tx_shift_d;
      prev_rx_q  <= rx_i;
    end
  end

`ifndef SYNTHESIS
  a_done_starts_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.step && res_o.byte_done |=> phase_q == PhTxStart)
    else $error("accepted stop bit did not start transmission");
  a_fstart_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.step && res_o.false_start |=> phase_q == PhIdle)
    else $error("false start did not return to idle");
  a_ferr_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.step && res_o.framing_error |=> phase_q == PhIdle)
    else $error("framing error did not return to idle");
  a_busy_outside_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.step && phase_q != PhIdle |-> res_o.busy_res)
    else $error("busy low during a frame");
`endif

endmodule

// ----- hw/rtl/uart_case_toggle_echo.sv -----
// top level of the uart 8n1 case-toggle echo: sample register, frame fsm, result register
// depends on uct_pkg, uct_smp_if, uct_res_if, uct_cfg_if and uct_fsm
//
//  channel  dir  payload                                        transfer when
//  smp_i    in   rx_level                                       valid & ready
//  res_o    out  tx_level byte_done rx_byte framing_error       valid & ready
//                false_start busy_res
//  cfg_i    in   bit_ticks                                      valid & ready (ready tied high)
//
// one result per sample; a sample can be taken every cycle while the result register is not stalled,
// and passes the sample register and then the result register; the sample register and the
// result register each hold one item; the fsm steps on the cycle a sample moves into the result register
// a stalled result register holds the sample register, which then drops smp_i.ready
// reset clears both valid flags, puts the fsm in idle and sets bit_ticks to 104
module uart_case_toggle_echo (
  input  logic clk_i,
  input  logic rst_ni,
  uct_smp_if.sink   smp_i,
  uct_res_if.source res_o,
  uct_cfg_if.sink   cfg_i
);
  import uct_pkg::*;

  logic      in_vld_q;
  logic      rx_q;
  logic      out_vld_q;
  res_t      out_q;
  res_t      step_res;
  tick_t     bit_ticks_q;
  logic      advance;
  step_ctl_t ctl;

  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign smp_i.ready = !in_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  assign ctl.step      = advance;
  assign ctl.bit_ticks = bit_ticks_q;

  uct_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .rx_i   (rx_q),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      bit_ticks_q <= BitTicksReset;
    end else begin
      if (smp_i.ready) begin
        in_vld_q <= smp_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        bit_ticks_q <= cfg_i.bit_ticks;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (smp_i.ready && smp_i.valid) begin
      rx_q <= smp_i.rx_level;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.tx_level      = out_q.tx_level;
  assign res_o.byte_done     = out_q.byte_done;
  assign res_o.rx_byte       = out_q.rx_byte;
  assign res_o.framing_error = out_q.framing_error;
  assign res_o.false_start   = out_q.false_start;
  assign res_o.busy_res      = out_q.busy_res;

endmodule

// ----- sim/tb_uart_case_toggle_echo.sv -----
// self-checking testbench for the uart case-toggle echo: line samples in, per-sample results out
// depends on uct_pkg, the uct_smp_if/uct_res_if/uct_cfg_if interfaces and uart_case_toggle_echo
// a sample-true predictor of the frame fsm checks every result field against the dut
module tb_uart_case_toggle_echo;
  import uct_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHold   = 80;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  uct_smp_if smp_ch ();
  uct_res_if res_ch ();
  uct_cfg_if cfg_ch ();

  uart_case_toggle_echo i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .smp_i (smp_ch),
    .res_o (res_ch),
    .cfg_i (cfg_ch)
  );

  // predictor state, mirrors the frame fsm
  phase_e   st_phase;
  tick_t    st_ticks;
  bit_idx_t st_bit;
  word_t    st_rx_word;
  word_t    st_tx_word;
  logic     st_prev_rx;
  tick_t    cur_bit_ticks;

  logic        rx_samples[$];
  res_t        pending_results[$];
  int unsigned n_queued;
  int unsigned n_errors;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_reqs;
  int unsigned hold_acks;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  // counts one tick of a wait; true once the wait of target ticks is over
  function automatic logic bit_wait_over(tick_t target);
    tick_t nxt;
    nxt = st_ticks + tick_t'(1);
    if (nxt >= target) begin
      st_ticks = '0;
      return 1'b1;
    end
    st_ticks = nxt;
    return 1'b0;
  endfunction

  function automatic res_t next_line_result(logic rx);
    res_t   r;
    phase_e was;
    word_t  w;
    r = '0;
    r.tx_level = 1'b1;
    was = st_phase;
    case (st_phase)
      PhIdle: begin
        if (st_prev_rx && !rx) begin
          st_phase = PhStart;
          st_ticks = '0;
        end
      end
      PhStart: begin
        if (bit_wait_over(cur_bit_ticks >> 1)) begin
          if (rx) begin
            r.false_start = 1'b1;
            st_phase = PhIdle;
          end else begin
            st_phase = PhData;
            st_bit = '0;
          end
        end
      end
      PhData: begin
        if (bit_wait_over(cur_bit_ticks)) begin
          st_rx_word = {rx, st_rx_word[DataBits-1:1]};
          if (st_bit == LastBit) begin
            st_bit = '0;
            st_phase = PhStop;
          end else begin
            st_bit = st_bit + bit_idx_t'(1);
          end
        end
      end
      PhStop: begin
        if (bit_wait_over(cur_bit_ticks)) begin
          if (rx) begin
            r.byte_done = 1'b1;
            r.rx_byte = 8'(st_rx_word);
            w = st_rx_word;
            if (w >= UpperFirst && w <= UpperLast) begin
              w = w + CaseOffset;
            end else if (w >= LowerFirst && w <= LowerLast) begin
              w = w - CaseOffset;
            end
            st_tx_word = w;
            st_bit = '0;
            st_phase = PhTxStart;
          end else begin
            r.framing_error = 1'b1;
            st_phase = PhIdle;
          end
        end
      end
      PhTxStart: begin
        r.tx_level = 1'b0;
        if (bit_wait_over(cur_bit_ticks)) begin
          st_bit = '0;
          st_phase = PhTxData;
        end
      end
      PhTxData: begin
        r.tx_level = st_tx_word[st_bit];
        if (bit_wait_over(cur_bit_ticks)) begin
          if (st_bit == LastBit) begin
            st_bit = '0;
            st_phase = PhTxStop;
          end else begin
            st_bit = st_bit + bit_idx_t'(1);
          end
        end
      end
      PhTxStop: begin
        if (bit_wait_over(cur_bit_ticks)) begin
          st_phase = PhIdle;
        end
      end
      default: begin
        st_phase = PhIdle;
        st_ticks = '0;
      end
    endcase
    st_prev_rx = rx;
    r.busy_res = (was != PhIdle) || (st_phase != PhIdle);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  // sample driver: predicts on every accepted sample
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_ch.valid <= 1'b0;
      smp_ch.rx_level <= 1'b1;
    end else begin
      if (smp_ch.valid && smp_ch.ready) begin
        pending_results.push_back(next_line_result(smp_ch.rx_level));
      end
      if (!smp_ch.valid || smp_ch.ready) begin
        if (rx_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          smp_ch.valid <= 1'b1;
          smp_ch.rx_level <= rx_samples.pop_front();
        end else begin
          smp_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stalls and an on-request long hold-off
  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no expected result waiting");
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("tx_level", want.tx_level, res_ch.tx_level);
          check_field("byte_done", want.byte_done, res_ch.byte_done);
          check_field("rx_byte", want.rx_byte, res_ch.rx_byte);
          check_field("framing_error", want.framing_error, res_ch.framing_error);
          check_field("false_start", want.false_start, res_ch.false_start);
          check_field("busy_res", want.busy_res, res_ch.busy_res);
        end
      end
      if (hold_reqs != hold_acks) begin
        hold_acks <= hold_reqs;
        hold_left <= LongHold;
        res_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // watchdog: too long without any transfer ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_level(logic lvl, int unsigned n);
    repeat (n) begin
      rx_samples.push_back(lvl);
      n_queued++;
    end
  endtask

  task automatic push_noise(int unsigned n);
    repeat (n) begin
      rx_samples.push_back(1'($urandom_range(1)));
      n_queued++;
    end
  endtask

  // one 8n1 frame, then, if the stop bit is high, the line during the echo: high, noise, or noise ending low
  task automatic push_frame(int unsigned bt, logic [7:0] data, logic stop_lvl);
    int unsigned echo_len;
    int unsigned tail_kind;
    echo_len = 9 * bt + bt / 2 + 1;
    tail_kind = $urandom_range(2);
    push_level(1'b1, $urandom_range(1, 3));
    push_level(1'b0, bt);
    for (int i = 0; i < DataBits; i++) begin
      push_level(data[i], bt);
    end
    push_level(stop_lvl, bt);
    if (stop_lvl) begin
      case (tail_kind)
        0: push_level(1'b1, echo_len);
        1: push_noise(echo_len);
        default: begin
          // line still low when the echo ends must not start a frame
          push_noise(echo_len - 2);
          push_level(1'b0, 4);
        end
      endcase
    end
  endtask

  task automatic push_random(int unsigned bt, int unsigned n);
    int unsigned goal;
    int unsigned pick;
    logic [7:0]  data;
    logic [7:0]  corner_bytes[10];
    corner_bytes = '{8'h00, 8'hFF, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
    goal = n_queued + n;
    while (n_queued < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(99) < 40) begin
          data = corner_bytes[$urandom_range(9)];
        end else begin
          data = 8'($urandom_range(255));
        end
        push_frame(bt, data, $urandom_range(9) != 0);
      end else if (pick < 85) begin
        push_noise($urandom_range(1, 4 * bt + 8));
        push_level(1'b1, 2);
      end else begin
        // frame cut short, then the line goes high
        push_level(1'b1, 2);
        push_level(1'b0, bt);
        push_noise($urandom_range(1, 8 * bt));
        push_level(1'b1, 2 * bt);
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (rx_samples.size() != 0 || smp_ch.valid || pending_results.size() != 0);
  endtask

  // drain, then hold the line high until the fsm is back in idle
  task automatic settle(int unsigned bt);
    wait_drained();
    while (st_phase != PhIdle) begin
      push_level(1'b1, bt);
      wait_drained();
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_bit_ticks(tick_t val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.bit_ticks <= val;
    do @(posedge clk_i);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_bit_ticks = val;
    @(negedge clk_i);
  endtask

  task automatic run_phase(tick_t bt, int unsigned idle_pct, int unsigned stall_pct,
                           int unsigned n);
    write_bit_ticks(bt);
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    push_random(bt, n);
    settle(bt);
  endtask

  initial begin
    rst_ni = 1'b0;
    smp_ch.valid = 1'b0;
    smp_ch.rx_level = 1'b1;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.bit_ticks = '0;
    st_phase = PhIdle;
    st_ticks = '0;
    st_bit = '0;
    st_rx_word = '0;
    st_tx_word = '0;
    st_prev_rx = 1'b1;
    cur_bit_ticks = BitTicksReset;
    n_queued = 0;
    n_errors = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_reqs = 0;
    hold_acks = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset bit period: false start caught half a bit after the edge
    push_level(1'b1, 2);
    push_level(1'b0, 1);
    push_level(1'b1, 60);
    settle(BitTicksReset);

    // shortest bit period: false start, then a framing error after all-ones data
    write_bit_ticks(tick_t'(2));
    push_level(1'b1, 1);
    push_level(1'b0, 1);
    push_level(1'b1, 1);
    push_level(1'b0, 2);
    push_level(1'b1, 16);
    push_level(1'b0, 2);
    push_random(2, 40);
    // sender pauses until every result is back
    wait_drained();
    push_random(2, 40);
    settle(2);

    run_phase(tick_t'(3), 72, 0, 90);

    // longest bit period: start bit left waiting, then a short period ends the wait
    write_bit_ticks(tick_t'(16'hFFFF));
    push_level(1'b1, 2);
    push_level(1'b0, 1);
    push_level(1'b1, 40);
    wait_drained();
    write_bit_ticks(tick_t'(2));
    settle(2);

    // receiver holds off while samples keep coming, so the input stalls
    write_bit_ticks(tick_t'(2));
    src_idle_pct = 0;
    snk_stall_pct = 72;
    push_random(2, 90);
    hold_reqs++;
    settle(2);

    run_phase(tick_t'(4), 37, 37, 90);

    repeat (10) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
